[rtl/gcd_pkg.sv]
// Shared widths, constants, types and the arctangent table for the great-circle distance core.
package gcd_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int RADIUS_W = 25;
	localparam int DIST_W   = 27;

	localparam int ANG_W = 34;   // angles in half-ticks of 1e-7 degree
	localparam int CW    = 34;   // CORDIC datapath, Q2.30 with headroom
	localparam int VAL_W = 32;   // clamped sine or cosine, Q2.30
	localparam int SQ_W  = 62;   // square-root remainder and partial root
	localparam int REM_W = 64;   // division remainder
	localparam int HV_W  = 31;   // haversine term and roots, 0 .. 2^30

	localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd7200000000;
	localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd3600000000;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1800000000;
	localparam logic signed [ANG_W-1:0] TURN_3Q      = 34'sd5400000000;

	localparam logic [31:0] RAD_SCALE = 32'd4024455254;
	localparam logic signed [CW-1:0] CORDIC_KINV = 34'sd652032874;
	localparam int ONE_Q30 = 1073741824;
	localparam int HALF_Q30_LSB = 536870912;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 25'd6371000;
	localparam logic [DIST_W-1:0]   DIST_MAX     = 27'd134217727;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic                 neg;
		logic                 xpos;
	} div_side_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [CW-1:0] atan_entry(input int i);
		logic signed [CW-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			10: r = 34'sd1048576;
			default: begin
				if (i <= 30)
					r = {{(CW-1){1'b0}}, 1'b1} << (30 - i);
				else
					r = '0;
			end
		endcase
		return r;
	endfunction

	// quotient bits needed for the residual correction after the vectoring row
	function automatic int div_bits(input int n);
		return (n >= 24) ? 10 : 34 - n;
	endfunction

endpackage

[rtl/gcd_rot_cell.sv]
// One rotation-mode CORDIC cell: a single micro-rotation towards zero residual angle.
module gcd_rot_cell #(
	parameter int STEP = 0
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [gcd_pkg::CW-1:0]    x,
	input  logic signed [gcd_pkg::CW-1:0]    y,
	input  logic signed [gcd_pkg::CW-1:0]    z,
	output logic signed [gcd_pkg::CW-1:0]    x_q,
	output logic signed [gcd_pkg::CW-1:0]    y_q,
	output logic signed [gcd_pkg::CW-1:0]    z_q
);
	localparam int CW = gcd_pkg::CW;
	localparam logic signed [CW-1:0] ATAN = gcd_pkg::atan_entry(STEP);

	logic signed [CW-1:0] dx, dy;

	assign dx = y >>> STEP;
	assign dy = x >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z[CW-1]) begin
				x_q <= x - dx;
				y_q <= y + dy;
				z_q <= z - ATAN;
			end else begin
				x_q <= x + dx;
				y_q <= y - dy;
				z_q <= z + ATAN;
			end
		end
	end

endmodule

[rtl/gcd_trig.sv]
// Sine or cosine of an angle in half-ticks: range reduction, radian scaling, CORDIC row, correction.
module gcd_trig #(
	parameter int STEPS   = gcd_pkg::CORDIC_STEPS_DEF,
	parameter bit SEL_SIN = 1'b1
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [gcd_pkg::ANG_W-1:0]    a,
	output logic signed [gcd_pkg::VAL_W-1:0]    val
);
	localparam int CW    = gcd_pkg::CW;
	localparam int ANG_W = gcd_pkg::ANG_W;
	localparam int VAL_W = gcd_pkg::VAL_W;
	localparam logic signed [ANG_W-1:0] FULL = gcd_pkg::FULL_TURN;
	localparam logic signed [ANG_W-1:0] HALF = gcd_pkg::HALF_TURN;
	localparam logic signed [ANG_W-1:0] QRTR = gcd_pkg::QUARTER_TURN;
	localparam logic signed [ANG_W-1:0] T3Q  = gcd_pkg::TURN_3Q;
	localparam logic signed [CW:0] ONE = (CW+1)'(gcd_pkg::ONE_Q30);
	localparam logic signed [2*CW-1:0] RND30 = (2*CW)'(gcd_pkg::HALF_Q30_LSB);

	logic signed [ANG_W-1:0] a_s1;
	logic signed [ANG_W-1:0] adj;
	logic                    fl;
	logic signed [ANG_W-1:0] ar;
	logic signed [VAL_W-1:0] ar_s2;
	logic                    flip_s2;
	logic [VAL_W-1:0]        mag;
	logic [62:0]             prod_s3;
	logic                    neg_s3;
	logic [62:0]             rnd;
	logic signed [CW-1:0]    zr;
	logic signed [CW-1:0]    z_s4;
	logic [STEPS+2:0]        fl_q;
	logic signed [CW-1:0]    xs [0:STEPS];
	logic signed [CW-1:0]    ys [0:STEPS];
	logic signed [CW-1:0]    zs [0:STEPS];
	logic signed [CW-1:0]    mul_a;
	logic signed [2*CW-1:0]  prod_s5;
	logic signed [CW-1:0]    base_s5;
	logic signed [2*CW-1:0]  rp;
	logic signed [CW:0]      v;
	logic signed [CW:0]      vc;
	logic signed [VAL_W-1:0] cl;
	logic signed [VAL_W-1:0] val_s6;

	// reduce modulo a full turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (a >= FULL)
				a_s1 <= a - FULL;
			else if (a <= -FULL)
				a_s1 <= a + FULL;
			else
				a_s1 <= a;
		end
	end

	// wrap to a half turn, then fold into a quarter turn with a sign flip
	always_comb begin
		adj = '0;
		fl  = 1'b0;
		if (a_s1 > HALF) begin
			if (a_s1 < T3Q) begin
				adj = -HALF;
				fl  = 1'b1;
			end else begin
				adj = -FULL;
			end
		end else if (a_s1 <= -HALF) begin
			if (a_s1 > -T3Q) begin
				adj = HALF;
				fl  = 1'b1;
			end else begin
				adj = FULL;
			end
		end else if (a_s1 > QRTR) begin
			adj = -HALF;
			fl  = 1'b1;
		end else if (a_s1 < -QRTR) begin
			adj = HALF;
			fl  = 1'b1;
		end
		ar = a_s1 + adj;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ar_s2   <= VAL_W'(ar);
			flip_s2 <= fl;
		end
	end

	// scale to Q2.30 radians
	assign mag = ar_s2[VAL_W-1] ? VAL_W'(-ar_s2) : VAL_W'(ar_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= 63'(mag[VAL_W-2:0]) * 63'(gcd_pkg::RAD_SCALE);
			neg_s3  <= ar_s2[VAL_W-1];
		end
	end

	assign rnd = prod_s3 + 63'h80000000;
	assign zr  = $signed(CW'(rnd >> 32));

	always_ff @(posedge clk) begin
		if (en)
			z_s4 <= neg_s3 ? -zr : zr;
	end

	always_ff @(posedge clk) begin
		if (en)
			fl_q <= {fl_q[STEPS+1:0], flip_s2};
	end

	assign xs[0] = gcd_pkg::CORDIC_KINV;
	assign ys[0] = '0;
	assign zs[0] = z_s4;

	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		gcd_rot_cell #(
			.STEP (k)
		) u_cell (
			.clk (clk),
			.en  (en),
			.x   (xs[k]),
			.y   (ys[k]),
			.z   (zs[k]),
			.x_q (xs[k+1]),
			.y_q (ys[k+1]),
			.z_q (zs[k+1])
		);
	end

	// first-order correction from the residual angle
	assign mul_a = SEL_SIN ? xs[STEPS] : ys[STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= mul_a * zs[STEPS];
			base_s5 <= SEL_SIN ? ys[STEPS] : xs[STEPS];
		end
	end

	always_comb begin
		rp = (prod_s5 + RND30) >>> 30;
		if (SEL_SIN)
			v = (CW+1)'(base_s5) + (CW+1)'(rp);
		else
			v = (CW+1)'(base_s5) - (CW+1)'(rp);
		if (v > ONE)
			vc = ONE;
		else if (v < -ONE)
			vc = -ONE;
		else
			vc = v;
		cl = VAL_W'(vc);
	end

	always_ff @(posedge clk) begin
		if (en)
			val_s6 <= fl_q[STEPS+2] ? -cl : cl;
	end

	assign val = val_s6;

endmodule

[rtl/gcd_sqrt_cell.sv]
// One digit of a restoring square root: try the current bit, keep or drop it.
module gcd_sqrt_cell #(
	parameter int K = 0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [gcd_pkg::SQ_W-1:0]    v,
	input  logic [gcd_pkg::SQ_W-1:0]    r,
	output logic [gcd_pkg::SQ_W-1:0]    v_q,
	output logic [gcd_pkg::SQ_W-1:0]    r_q
);
	localparam int SQ_W = gcd_pkg::SQ_W;
	localparam logic [SQ_W-1:0] BITV = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * K);

	logic [SQ_W-1:0] trial;

	assign trial = r + BITV;

	always_ff @(posedge clk) begin
		if (en) begin
			if (v >= trial) begin
				v_q <= v - trial;
				r_q <= (r >> 1) + BITV;
			end else begin
				v_q <= v;
				r_q <= r >> 1;
			end
		end
	end

endmodule

[rtl/gcd_vec_cell.sv]
// One vectoring-mode CORDIC cell: rotate the vector towards the x axis and accumulate the angle.
module gcd_vec_cell #(
	parameter int STEP = 0
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [gcd_pkg::CW-1:0]    x,
	input  logic signed [gcd_pkg::CW-1:0]    y,
	input  logic signed [gcd_pkg::CW-1:0]    z,
	output logic signed [gcd_pkg::CW-1:0]    x_q,
	output logic signed [gcd_pkg::CW-1:0]    y_q,
	output logic signed [gcd_pkg::CW-1:0]    z_q
);
	localparam int CW = gcd_pkg::CW;
	localparam logic signed [CW-1:0] ATAN = gcd_pkg::atan_entry(STEP);

	logic signed [CW-1:0] dx, dy;

	assign dx = y >>> STEP;
	assign dy = x >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y > 0) begin
				x_q <= x + dx;
				y_q <= y - dy;
				z_q <= z + ATAN;
			end else begin
				x_q <= x - dx;
				y_q <= y + dy;
				z_q <= z - ATAN;
			end
		end
	end

endmodule

[rtl/gcd_div_cell.sv]
// One quotient bit of a restoring divider, carrying the angle and sign alongside.
module gcd_div_cell #(
	parameter int QW = 10,
	parameter int K  = 0
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [gcd_pkg::REM_W-1:0]    rem,
	input  logic [gcd_pkg::CW-1:0]       d,
	input  logic [QW-1:0]                q,
	input  gcd_pkg::div_side_t           side,
	output logic [gcd_pkg::REM_W-1:0]    rem_q,
	output logic [gcd_pkg::CW-1:0]       d_q,
	output logic [QW-1:0]                q_q,
	output gcd_pkg::div_side_t           side_q
);
	localparam int REM_W = gcd_pkg::REM_W;
	localparam logic [QW-1:0] QBIT = {{(QW-1){1'b0}}, 1'b1} << K;

	logic [REM_W-1:0] dk;

	assign dk = REM_W'(d) << K;

	always_ff @(posedge clk) begin
		if (en) begin
			d_q    <= d;
			side_q <= side;
			if (rem >= dk) begin
				rem_q <= rem - dk;
				q_q   <= q | QBIT;
			end else begin
				rem_q <= rem;
				q_q   <= q;
			end
		end
	end

endmodule

[rtl/great_circle_distance_core.sv]
// Top level of the great-circle distance core: haversine distance between two points.
//
// Requests arrive on the s_ channel, one pair of points per beat, latitude and
// longitude in signed units of 1e-7 degree. Each request yields one result on
// the m_ channel: the distance in whole metres, rounded to nearest and
// saturated at 2^27-1. The sphere radius in metres is written on the cfg_
// channel, which is always ready; write it only while no request is in flight.
//
// The datapath is a fixed pipeline of cells: four CORDIC sine/cosine rows,
// the haversine products, two 31-digit square-root rows, a vectoring CORDIC
// row for the arctangent, a restoring divider for its residual and the final
// scaling by the radius. A new request is taken in every cycle unless a
// finished result is waiting to be taken.
//
// When the receiver holds m_tready low while a result is waiting, the whole
// pipeline holds and s_tready drops until the result is taken.
// Reset empties the pipeline and loads the radius with 6371000 m.
module great_circle_distance_core #(
	parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [127:0]                      s_tdata,   // lat_a, lon_a, lat_b, lon_b
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // distance_m
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gcd_pkg::RADIUS_W-1:0]      cfg_data   // earth_radius_m
);
	localparam int CW     = gcd_pkg::CW;
	localparam int ANG_W  = gcd_pkg::ANG_W;
	localparam int VAL_W  = gcd_pkg::VAL_W;
	localparam int SQ_W   = gcd_pkg::SQ_W;
	localparam int REM_W  = gcd_pkg::REM_W;
	localparam int HV_W   = gcd_pkg::HV_W;
	localparam int LAT_W  = gcd_pkg::LAT_W;
	localparam int LON_W  = gcd_pkg::LON_W;
	localparam int RAD_W  = gcd_pkg::RADIUS_W;
	localparam int DIST_W = gcd_pkg::DIST_W;
	localparam int QW     = gcd_pkg::div_bits(CORDIC_STEPS);
	localparam int LAT    = 2 * CORDIC_STEPS + QW + 48;
	localparam int SQ_N   = 31;
	localparam logic [61:0] RND30 = 62'(gcd_pkg::HALF_Q30_LSB);
	localparam logic signed [32:0] ONE33 = 33'(gcd_pkg::ONE_Q30);
	localparam logic [HV_W-1:0] ONE_HV = HV_W'(gcd_pkg::ONE_Q30);

	logic en;
	logic [LAT-1:0] vld_q;
	logic [RAD_W-1:0] radius_q;

	logic signed [LAT_W-1:0] lat_a, lat_b;
	logic signed [LON_W-1:0] lon_a, lon_b;
	logic signed [ANG_W-1:0] dlat_s1, dlon_s1, twa_s1, twb_s1;
	logic signed [VAL_W-1:0] s_lat, s_lon, c_a, c_b;

	logic [HV_W-1:0] asl, aso, aca, acb;
	logic [61:0] sl_p_s1, so_p_s1, cc_p_s1;
	logic        ccneg_s1, ccneg_s2, ccneg_s3;
	logic [HV_W-1:0] sl2_s2, so2_s2, cc_s2, sl2_s3;
	logic [61:0] term_s3;
	logic [HV_W-1:0] trm;
	logic signed [32:0] pv;
	logic [HV_W-1:0] p_s4, p_s5, q_s5;

	logic [SQ_W-1:0] pv_c [0:SQ_N];
	logic [SQ_W-1:0] pr_c [0:SQ_N];
	logic [SQ_W-1:0] qv_c [0:SQ_N];
	logic [SQ_W-1:0] qr_c [0:SQ_N];
	logic [HV_W-1:0] rt_p_s1, rt_q_s1;

	logic signed [CW-1:0] vx [0:CORDIC_STEPS];
	logic signed [CW-1:0] vy [0:CORDIC_STEPS];
	logic signed [CW-1:0] vz [0:CORDIC_STEPS];

	logic signed [CW-1:0] yl;
	logic [REM_W-1:0] dv_rem_s1;
	logic [CW-1:0]    dv_d_s1;
	gcd_pkg::div_side_t dv_side_s1;

	logic [REM_W-1:0] drem [0:QW];
	logic [CW-1:0]    dd   [0:QW];
	logic [QW-1:0]    dq   [0:QW];
	gcd_pkg::div_side_t dside [0:QW];

	logic signed [CW-1:0] qs, zz;
	logic [HV_W-1:0] zf_s1;
	logic [55:0] dprod_s2;
	logic [55:0] drnd;
	logic [DIST_W-1:0] dist_s3;

	// the pipeline moves unless a finished result is held up
	assign en        = !vld_q[LAT-1] || m_tready;
	assign s_tready  = en;
	assign m_tvalid  = vld_q[LAT-1];
	assign m_tdata   = {{(32-DIST_W){1'b0}}, dist_s3};
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gcd_pkg::RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// unpack and form the half-differences and the doubled latitudes in half-ticks
	assign lat_a = $signed(s_tdata[30:0]);
	assign lon_a = $signed(s_tdata[62:31]);
	assign lat_b = $signed(s_tdata[93:63]);
	assign lon_b = $signed(s_tdata[125:94]);

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= ANG_W'(lat_b) - ANG_W'(lat_a);
			dlon_s1 <= ANG_W'(lon_b) - ANG_W'(lon_a);
			twa_s1  <= ANG_W'(lat_a) <<< 1;
			twb_s1  <= ANG_W'(lat_b) <<< 1;
		end
	end

	gcd_trig #(.STEPS(CORDIC_STEPS), .SEL_SIN(1'b1)) u_sin_lat (
		.clk (clk), .en (en), .a (dlat_s1), .val (s_lat)
	);
	gcd_trig #(.STEPS(CORDIC_STEPS), .SEL_SIN(1'b1)) u_sin_lon (
		.clk (clk), .en (en), .a (dlon_s1), .val (s_lon)
	);
	gcd_trig #(.STEPS(CORDIC_STEPS), .SEL_SIN(1'b0)) u_cos_a (
		.clk (clk), .en (en), .a (twa_s1), .val (c_a)
	);
	gcd_trig #(.STEPS(CORDIC_STEPS), .SEL_SIN(1'b0)) u_cos_b (
		.clk (clk), .en (en), .a (twb_s1), .val (c_b)
	);

	// haversine term
	assign asl = s_lat[VAL_W-1] ? HV_W'(-s_lat) : HV_W'(s_lat);
	assign aso = s_lon[VAL_W-1] ? HV_W'(-s_lon) : HV_W'(s_lon);
	assign aca = c_a[VAL_W-1] ? HV_W'(-c_a) : HV_W'(c_a);
	assign acb = c_b[VAL_W-1] ? HV_W'(-c_b) : HV_W'(c_b);

	always_ff @(posedge clk) begin
		if (en) begin
			sl_p_s1  <= 62'(asl) * 62'(asl);
			so_p_s1  <= 62'(aso) * 62'(aso);
			cc_p_s1  <= 62'(aca) * 62'(acb);
			ccneg_s1 <= c_a[VAL_W-1] ^ c_b[VAL_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sl2_s2   <= HV_W'((sl_p_s1 + RND30) >> 30);
			so2_s2   <= HV_W'((so_p_s1 + RND30) >> 30);
			cc_s2    <= HV_W'((cc_p_s1 + RND30) >> 30);
			ccneg_s2 <= ccneg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s3  <= 62'(cc_s2) * 62'(so2_s2);
			sl2_s3   <= sl2_s2;
			ccneg_s3 <= ccneg_s2;
		end
	end

	always_comb begin
		trm = HV_W'((term_s3 + RND30) >> 30);
		if (ccneg_s3)
			pv = $signed({2'b00, sl2_s3}) - $signed({2'b00, trm});
		else
			pv = $signed({2'b00, sl2_s3}) + $signed({2'b00, trm});
	end

	// clamp to the unit interval
	always_ff @(posedge clk) begin
		if (en) begin
			if (pv < 0)
				p_s4 <= '0;
			else if (pv > ONE33)
				p_s4 <= ONE_HV;
			else
				p_s4 <= HV_W'(pv);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= p_s4;
			q_s5 <= ONE_HV - p_s4;
		end
	end

	// square roots of p and 1-p
	assign pv_c[0] = SQ_W'(p_s5) << 30;
	assign pr_c[0] = '0;
	assign qv_c[0] = SQ_W'(q_s5) << 30;
	assign qr_c[0] = '0;

	for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
		gcd_sqrt_cell #(.K(SQ_N - 1 - j)) u_p (
			.clk (clk), .en (en),
			.v (pv_c[j]), .r (pr_c[j]), .v_q (pv_c[j+1]), .r_q (pr_c[j+1])
		);
		gcd_sqrt_cell #(.K(SQ_N - 1 - j)) u_q (
			.clk (clk), .en (en),
			.v (qv_c[j]), .r (qr_c[j]), .v_q (qv_c[j+1]), .r_q (qr_c[j+1])
		);
	end

	// round the roots to nearest
	always_ff @(posedge clk) begin
		if (en) begin
			rt_p_s1 <= HV_W'((pv_c[SQ_N] > pr_c[SQ_N]) ? pr_c[SQ_N] + 1'b1 : pr_c[SQ_N]);
			rt_q_s1 <= HV_W'((qv_c[SQ_N] > qr_c[SQ_N]) ? qr_c[SQ_N] + 1'b1 : qr_c[SQ_N]);
		end
	end

	// half central angle as atan2(sqrt(p), sqrt(1-p))
	assign vx[0] = $signed(CW'(rt_q_s1));
	assign vy[0] = $signed(CW'(rt_p_s1));
	assign vz[0] = '0;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
		gcd_vec_cell #(.STEP(k)) u_cell (
			.clk (clk), .en (en),
			.x (vx[k]), .y (vy[k]), .z (vz[k]),
			.x_q (vx[k+1]), .y_q (vy[k+1]), .z_q (vz[k+1])
		);
	end

	// residual y/x by long division on magnitudes
	assign yl = vy[CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s1       <= REM_W'(yl[CW-1] ? CW'(-yl) : CW'(yl)) << 30;
			dv_d_s1         <= CW'(vx[CORDIC_STEPS]);
			dv_side_s1.z    <= vz[CORDIC_STEPS];
			dv_side_s1.neg  <= yl[CW-1];
			dv_side_s1.xpos <= (vx[CORDIC_STEPS] > 0);
		end
	end

	assign drem[0]  = dv_rem_s1;
	assign dd[0]    = dv_d_s1;
	assign dq[0]    = '0;
	assign dside[0] = dv_side_s1;

	for (genvar j = 0; j < QW; j++) begin : g_div
		gcd_div_cell #(.QW(QW), .K(QW - 1 - j)) u_cell (
			.clk (clk), .en (en),
			.rem (drem[j]), .d (dd[j]), .q (dq[j]), .side (dside[j]),
			.rem_q (drem[j+1]), .d_q (dd[j+1]), .q_q (dq[j+1]), .side_q (dside[j+1])
		);
	end

	always_comb begin
		qs = dside[QW].neg ? -$signed(CW'(dq[QW])) : $signed(CW'(dq[QW]));
		zz = dside[QW].xpos ? dside[QW].z + qs : dside[QW].z;
	end

	always_ff @(posedge clk) begin
		if (en)
			zf_s1 <= zz[CW-1] ? '0 : HV_W'(zz);
	end

	// scale by the radius; the angle is twice z, hence the shift by 29
	always_ff @(posedge clk) begin
		if (en)
			dprod_s2 <= 56'(radius_q) * 56'(zf_s1);
	end

	assign drnd = (dprod_s2 + 56'(1 << 28)) >> 29;

	always_ff @(posedge clk) begin
		if (en) begin
			if (drnd > 56'(gcd_pkg::DIST_MAX))
				dist_s3 <= gcd_pkg::DIST_MAX;
			else
				dist_s3 <= DIST_W'(drnd);
		end
	end

endmodule
